@@ design/bdp_pkg.sv @@
package bdp_pkg;

  // Queue between the multiplier front and the accumulator back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [31:0] fp32_t;
  typedef logic [15:0] bf16_t;

  localparam fp32_t Fp32CanonNan  = 32'h7FC0_0000;
  localparam fp32_t Fp32Inf       = 32'h7F80_0000;
  localparam fp32_t Fp32PosZero   = 32'h0000_0000;
  localparam fp32_t Bf16RoundBias = 32'h0000_7FFF;

  // One classified product on its way to the accumulator
  typedef struct packed {
    logic  last;
    fp32_t prod;
  } prod_item_t;

endpackage

@@ design/bdp_if.sv @@
interface bdp_in_if;
  logic          valid;
  logic          ready;
  bdp_pkg::bf16_t x_element;
  bdp_pkg::bf16_t w_element;
  logic          last_element;

  modport source (output valid, output x_element, output w_element, output last_element,
                  input ready);
  modport sink (input valid, input x_element, input w_element, input last_element,
                output ready);
endinterface

interface bdp_out_if;
  logic          valid;
  logic          ready;
  bdp_pkg::bf16_t result_bf16;

  modport source (output valid, output result_bf16, input ready);
  modport sink (input valid, input result_bf16, output ready);
endinterface

@@ design/bdp_front.sv @@
module bdp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  bdp_in_if.sink              in_i,
  output logic                item_valid_o,
  output bdp_pkg::prod_item_t item_o,
  input  logic                item_ready_i
);

  // Exact BF16 x BF16 product rounded to FP32 (only subnormal results round)
  function automatic bdp_pkg::fp32_t bf16_mul(input bdp_pkg::bf16_t a, input bdp_pkg::bf16_t b);
    logic               s;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         ea, eb, sa, sb;
    logic [8:0]         esum;
    logic [15:0]        p;
    logic [3:0]         lp;
    logic [15:0]        pn;
    logic signed [10:0] eb_n;
    logic [8:0]         sh;
    logic [33:0]        ext;
    logic [23:0]        frac;
    logic               up;
    bdp_pkg::fp32_t     r;
    s      = a[15] ^ b[15];
    a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
    b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
    a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
    b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'd0);
    a_zero = (a[14:0] == 15'd0);
    b_zero = (b[14:0] == 15'd0);
    ea     = (a[14:7] == 8'd0) ? 8'd1 : a[14:7];
    eb     = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
    sa     = {a[14:7] != 8'd0, a[6:0]};
    sb     = {b[14:7] != 8'd0, b[6:0]};
    esum   = {1'b0, ea} + {1'b0, eb};
    p      = sa * sb;
    lp     = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (p[i]) lp = 4'(i);
    end
    eb_n = $signed({2'b00, esum}) - 11'sd141 + $signed({7'd0, lp});
    pn   = p << (4'd15 - lp);
    sh   = 9'd119 - esum;
    if (sh > 9'd18) sh = 9'd18;
    ext  = {p, 18'd0} >> sh;
    up   = ext[17] & ((|ext[16:0]) | ext[18]);
    frac = 24'd0;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      r = bdp_pkg::Fp32CanonNan;
    end else if (a_inf || b_inf) begin
      r = {s, bdp_pkg::Fp32Inf[30:0]};
    end else if (p == 16'd0) begin
      r = {s, 31'd0};
    end else if (eb_n >= 11'sd255) begin
      r = {s, bdp_pkg::Fp32Inf[30:0]};
    end else if (eb_n >= 11'sd1) begin
      r = {s, eb_n[7:0], pn[14:0], 8'd0};
    end else if (esum >= 9'd119) begin
      frac = {8'd0, p} << (esum - 9'd119);
      r    = {s, 7'd0, frac};
    end else begin
      frac = {8'd0, ext[33:18]} + 24'(up);
      r    = {s, 7'd0, frac};
    end
    return r;
  endfunction

  logic                valid_q;
  bdp_pkg::prod_item_t item_q;
  logic                load;

  // Take a new item whenever the product stage is empty or moves on
  assign in_i.ready = !valid_q || item_ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Register the classified product
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.prod <= bf16_mul(in_i.x_element, in_i.w_element);
      item_q.last <= in_i.last_element;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ design/bdp_fifo.sv @@
module bdp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  bdp_pkg::prod_item_t push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_i,
  output bdp_pkg::prod_item_t pop_item_o
);

  bdp_pkg::prod_item_t                 mem_q [bdp_pkg::FifoDepth];
  logic [bdp_pkg::FifoAw-1:0]          wr_ptr_q, rd_ptr_q;
  logic [bdp_pkg::FifoCntW-1:0]        count_q;
  logic                                push, pop;

  assign push_ready_o = (count_q != bdp_pkg::FifoCntW'(bdp_pkg::FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  // Store the incoming item
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bdp_pkg::FifoCntW'(bdp_pkg::FifoDepth))
    else $error("queue fill level beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill level not raised on push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree when empty");

endmodule

@@ design/bdp_back.sv @@
module bdp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  bdp_pkg::prod_item_t item_i,
  output logic                pop_o,
  bdp_out_if.source           out_o
);

  // IEEE FP32 addition, round to nearest even, subnormals kept, NaN made canonical
  function automatic bdp_pkg::fp32_t fp32_add(input bdp_pkg::fp32_t a, input bdp_pkg::fp32_t b);
    logic           a_nan, b_nan, a_inf, b_inf;
    bdp_pkg::fp32_t x, y;
    logic [7:0]     ex, ey, d, lim;
    logic [23:0]    sx, sy;
    logic [4:0]     dc, lz, shl;
    logic [50:0]    shb;
    logic [26:0]    b27, n;
    logic [27:0]    sm;
    logic [8:0]     e;
    logic [7:0]     ef;
    logic           up, sgn;
    logic [30:0]    mag;
    bdp_pkg::fp32_t r;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:0] == bdp_pkg::Fp32Inf[30:0]);
    b_inf = (b[30:0] == bdp_pkg::Fp32Inf[30:0]);
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    sx  = {x[30:23] != 8'd0, x[22:0]};
    sy  = {y[30:23] != 8'd0, y[22:0]};
    d   = ex - ey;
    dc  = (d > 8'd27) ? 5'd27 : d[4:0];
    shb = {sy, 27'd0} >> dc;
    b27 = shb[50:24];
    b27[0] = b27[0] | (|shb[23:0]);
    if (x[31] == y[31]) sm = {1'b0, sx, 3'd0} + {1'b0, b27};
    else                sm = {1'b0, sx, 3'd0} - {1'b0, b27};
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sm[i]) lz = 5'(26 - i);
    end
    lim = ex - 8'd1;
    if (lim > 8'd27) lim = 8'd27;
    shl = (lz < lim[4:0]) ? lz : lim[4:0];
    if (sm[27]) begin
      n = {sm[27:2], sm[1] | sm[0]};
      e = {1'b0, ex} + 9'd1;
    end else begin
      n = sm[26:0] << shl;
      e = {1'b0, ex} - {4'd0, shl};
    end
    ef  = n[26] ? e[7:0] : 8'd0;
    up  = n[2] & (n[1] | n[0] | n[3]);
    mag = {ef, n[25:3]} + 31'(up);
    if (ef == 8'hFF) mag = bdp_pkg::Fp32Inf[30:0];
    sgn = (sm == 28'd0) ? (x[31] & y[31]) : x[31];
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]))) r = bdp_pkg::Fp32CanonNan;
    else if (a_inf)                                             r = a;
    else if (b_inf)                                             r = b;
    else                                                        r = {sgn, mag};
    return r;
  endfunction

  bdp_pkg::fp32_t acc_q, acc_d;
  bdp_pkg::fp32_t sum;
  bdp_pkg::fp32_t biased;
  logic           out_valid_q;
  bdp_pkg::bf16_t result_q;

  // Hold a last item back only while the result register is still occupied
  assign pop_o  = item_valid_i && (!item_i.last || !out_valid_q || out_o.ready);
  assign sum    = fp32_add(acc_q, item_i.prod);
  assign biased = sum + bdp_pkg::Bf16RoundBias + {31'd0, sum[16]};

  always_comb begin
    acc_d = acc_q;
    if (pop_o) acc_d = item_i.last ? bdp_pkg::Fp32PosZero : sum;
  end

  // Accumulate; clear after the last element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= bdp_pkg::Fp32PosZero;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (pop_o && item_i.last) out_valid_q <= 1'b1;
      else if (out_o.ready)     out_valid_q <= 1'b0;
    end
  end

  // Round the finished sum to BF16
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) result_q <= biased[31:16];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_bf16 = result_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> acc_q == bdp_pkg::Fp32PosZero)
    else $error("accumulator not cleared after last element");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0) |-> acc_q == bdp_pkg::Fp32CanonNan)
    else $error("accumulator holds a non-canonical NaN");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> acc_q == $past(acc_q))
    else $error("accumulator changed without an item");

endmodule

@@ design/bf16_dot_product_fp32_accumulate.sv @@
// BF16 dot product with FP32 accumulation.
// in_i carries one BF16 activation, one BF16 weight and a last flag per item;
// out_o carries one BF16 result for each run of items closed by last.
// Items stream at one per cycle unless back-pressure stalls them. The front
// multiplies the pair into FP32 (only subnormal products round) and registers
// it; a four-entry queue then feeds the back, which adds the product into the
// FP32 accumulator with round-to-nearest-even through a combinational adder,
// so the accumulator loop takes one item per cycle unless a last item is held.
// A last item passes the product register, then a queue entry; the result
// register loads as the queue pops it, and the result is then valid.
// When the receiver stalls, the result register holds its value; non-last
// items keep draining into the accumulator, a further last item waits in the
// queue, and in_i.ready drops once the queue and product stage are full.
// Reset clears the accumulator to +0 and empties the queue and the result
// register; no item is lost or duplicated across a stall.
module bf16_dot_product_fp32_accumulate (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdp_in_if.sink    in_i,
  bdp_out_if.source out_o
);

  logic                front_valid, front_ready;
  bdp_pkg::prod_item_t front_item;
  logic                q_valid, q_pop;
  bdp_pkg::prod_item_t q_item;

  bdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (front_ready)
  );

  bdp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  bdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

endmodule

@@ sim/bf16_dot_product_fp32_accumulate_test.sv @@
`timescale 1ns / 100ps

module bf16_dot_product_fp32_accumulate_test;

  localparam int unsigned StallLimit = 2000;

  typedef struct {
    bdp_pkg::bf16_t x;
    bdp_pkg::bf16_t w;
    logic           last;
    int unsigned    gap;
    bit             drain;
  } mac_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bdp_in_if  in_if ();
  bdp_out_if out_if ();

  bf16_dot_product_fp32_accumulate DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  mac_item_t      pending_items[$];
  bdp_pkg::bf16_t dot_results_due[$];
  bdp_pkg::fp32_t dot_sum = bdp_pkg::Fp32PosZero;
  int unsigned    n_items_in = 0;
  int unsigned    n_results = 0;
  int unsigned    n_errors = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    in_gap = 0;
  int unsigned    out_stall = 0;
  bit             in_taken = 1'b0;

  // Round an exact value mag * 2^e2 to FP32, nearest-even, subnormals kept
  function automatic bdp_pkg::fp32_t fp32_round_pack(bit sgn, logic [127:0] mag, int e2);
    int          p;
    int          sh;
    int          eb;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] half;
    if (mag == '0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    sh = p - 23;
    if (-149 - e2 > sh) sh = -149 - e2;
    if (sh > 127) begin
      q = '0;
    end else if (sh > 0) begin
      q    = mag >> sh;
      rem  = mag & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 128'd1;
    end else begin
      q = mag << (-sh);
    end
    if (q == '0) return {sgn, 31'd0};
    eb = sh + e2 + 150;
    if (q[24]) begin
      q  = q >> 1;
      eb = eb + 1;
    end
    if (!q[23]) eb = 0;
    if (eb >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, eb[7:0], q[22:0]};
  endfunction

  function automatic bit fp32_is_nan(bdp_pkg::fp32_t a);
    return (a[30:0] > bdp_pkg::Fp32Inf[30:0]);
  endfunction

  // Exact product of two BF16 operands, rounded once to FP32
  function automatic bdp_pkg::fp32_t bf16_product(bdp_pkg::bf16_t a, bdp_pkg::bf16_t b);
    bit        sgn;
    bit        a_nan;
    bit        b_nan;
    bit        a_inf;
    bit        b_inf;
    logic [7:0] ma;
    logic [7:0] mb;
    logic [15:0] mp;
    int        ea;
    int        eb;
    sgn   = a[15] ^ b[15];
    a_nan = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
    b_nan = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
    a_inf = (a[14:0] == 15'h7F80);
    b_inf = (b[14:0] == 15'h7F80);
    if (a_nan || b_nan || (a_inf && b[14:0] == 15'd0) || (b_inf && a[14:0] == 15'd0))
      return bdp_pkg::Fp32CanonNan;
    if (a_inf || b_inf) return {sgn, 8'hFF, 23'd0};
    ma = {(a[14:7] != 8'd0), a[6:0]};
    mb = {(b[14:7] != 8'd0), b[6:0]};
    ea = (a[14:7] != 8'd0) ? int'(a[14:7]) - 134 : -133;
    eb = (b[14:7] != 8'd0) ? int'(b[14:7]) - 134 : -133;
    mp = ma * mb;
    return fp32_round_pack(sgn, 128'(mp), ea + eb);
  endfunction

  // FP32 addition, nearest-even; any NaN comes out canonical
  function automatic bdp_pkg::fp32_t fp32_sum(bdp_pkg::fp32_t a, bdp_pkg::fp32_t b);
    bit          sa;
    bit          sb;
    bit          sr;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [23:0] mt;
    int          ea;
    int          eb;
    int          et;
    logic [127:0] va;
    logic [127:0] vb;
    logic [127:0] mag;
    if (fp32_is_nan(a) || fp32_is_nan(b)) return bdp_pkg::Fp32CanonNan;
    if (a[30:0] == bdp_pkg::Fp32Inf[30:0] && b[30:0] == bdp_pkg::Fp32Inf[30:0] &&
        a[31] != b[31])
      return bdp_pkg::Fp32CanonNan;
    if (a[30:0] == bdp_pkg::Fp32Inf[30:0]) return a;
    if (b[30:0] == bdp_pkg::Fp32Inf[30:0]) return b;
    sa = a[31];
    sb = b[31];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    ea = (a[30:23] != 8'd0) ? int'(a[30:23]) - 150 : -149;
    eb = (b[30:23] != 8'd0) ? int'(b[30:23]) - 150 : -149;
    // keep the larger exponent in ea
    if (eb > ea) begin
      mt = ma; ma = mb; mb = mt;
      et = ea; ea = eb; eb = et;
      sr = sa; sa = sb; sb = sr;
    end
    // a far smaller operand only acts as a sticky bit
    if (mb == 24'd0) eb = ea;
    else if (ea - eb > 50) begin
      mb = 24'd1;
      eb = ea - 50;
    end
    va = 128'(ma) << (ea - eb);
    vb = 128'(mb);
    if (sa == sb) begin
      mag = va + vb;
      sr  = sa;
    end else if (va >= vb) begin
      mag = va - vb;
      sr  = sa;
    end else begin
      mag = vb - va;
      sr  = sb;
    end
    if (mag == '0) return {sa & sb, 31'd0};
    return fp32_round_pack(sr, mag, eb);
  endfunction

  // Advance the accumulator by one accepted item; queue a result on last
  function automatic void accumulate_element(bdp_pkg::bf16_t x, bdp_pkg::bf16_t w,
                                             logic last);
    bdp_pkg::fp32_t rounded;
    dot_sum = fp32_sum(dot_sum, bf16_product(x, w));
    if (last) begin
      rounded = dot_sum + bdp_pkg::Bf16RoundBias + {31'd0, dot_sum[16]};
      dot_results_due.push_back(rounded[31:16]);
      dot_sum = bdp_pkg::Fp32PosZero;
    end
  endfunction

  function automatic bdp_pkg::bf16_t rand_bf16();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return {1'($urandom), 8'($urandom_range(108, 146)), 7'($urandom)};
    if (pick < 70) begin
      case ($urandom_range(0, 4))
        0: return {1'($urandom), 15'h7F80};
        1: return {1'($urandom), 15'd0};
        2: return {1'($urandom), 8'd0, 7'($urandom)};
        3: return {1'($urandom), 15'h7F7F};
        default: return {1'($urandom), 8'hFF, 7'($urandom_range(1, 127))};
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic void add_item(bdp_pkg::bf16_t x, bdp_pkg::bf16_t w, logic last,
                                   bit quiet, bit drain);
    mac_item_t it;
    it.x     = x;
    it.w     = w;
    it.last  = last;
    it.gap   = quiet ? 0 : $urandom_range(0, 8);
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  // Drive the input side at the falling edge
  always @(negedge clk_i) begin
    mac_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // hold the item until it is taken
    end else if (in_gap > 0) begin
      in_if.valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (pending_items.size() > 0 &&
                 !(pending_items[0].drain && dot_results_due.size() > 0)) begin
      it = pending_items.pop_front();
      in_if.x_element    <= it.x;
      in_if.w_element    <= it.w;
      in_if.last_element <= it.last;
      in_if.valid        <= 1'b1;
      in_gap = it.gap;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Stall the output side at the falling edge
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_if.ready <= rst_ni;
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    bdp_pkg::bf16_t want;
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (in_taken) begin
      accumulate_element(in_if.x_element, in_if.w_element, in_if.last_element);
      n_items_in = n_items_in + 1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results = n_results + 1;
      if (dot_results_due.size() == 0) begin
        $display("%0t: result 0x%04h with nothing expected", $time, out_if.result_bf16);
        n_errors = n_errors + 1;
      end else begin
        want = dot_results_due.pop_front();
        if (out_if.result_bf16 !== want) begin
          $display("%0t: result_bf16 expected 0x%04h actual 0x%04h",
                   $time, want, out_if.result_bf16);
          n_errors = n_errors + 1;
        end
      end
      out_stall = ((n_items_in / 200) % 3 == 2) ? 0 : $urandom_range(0, 8);
    end
    // watchdog on cycles with no handshake
    if (!rst_ni || in_taken || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("bf16_dot_product_fp32_accumulate: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    bit          quiet;
    bit          drain_set;
    bit          drain_now;
    in_if.valid        = 1'b0;
    in_if.x_element    = '0;
    in_if.w_element    = '0;
    in_if.last_element = 1'b0;
    out_if.ready       = 1'b0;
    drain_set          = 1'b0;

    // directed: zeros, extremes, specials, overflow and underflow
    add_item(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
    add_item(16'h8000, 16'h0000, 1'b1, 1'b0, 1'b0);
    add_item(16'h3F80, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h7F7F, 16'h7F7F, 1'b1, 1'b0, 1'b0);
    add_item(16'h7F7F, 16'h3F80, 1'b0, 1'b0, 1'b0);
    add_item(16'h7B00, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h7F80, 16'h0000, 1'b1, 1'b0, 1'b0);
    add_item(16'h7F80, 16'h3F80, 1'b0, 1'b0, 1'b0);
    add_item(16'hFF80, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h7FC1, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h0001, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h0080, 16'h0080, 1'b1, 1'b0, 1'b0);
    add_item(16'h1F80, 16'h9F80, 1'b1, 1'b0, 1'b0);
    add_item(16'hFFFF, 16'h7F7F, 1'b1, 1'b0, 1'b0);
    add_item(16'h3F80, 16'h3F80, 1'b0, 1'b0, 1'b0);
    add_item(16'hBF80, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h8000, 16'h3F80, 1'b0, 1'b0, 1'b0);
    add_item(16'h8000, 16'h3F80, 1'b1, 1'b0, 1'b0);
    add_item(16'h4049, 16'h4049, 1'b0, 1'b0, 1'b0);
    add_item(16'h3F81, 16'hBF80, 1'b0, 1'b0, 1'b0);
    add_item(16'h3F80, 16'h3B80, 1'b1, 1'b0, 1'b0);
    add_item(16'hFF7F, 16'h7F7F, 1'b1, 1'b0, 1'b0);

    // random dot products of mixed length, with some loose noise items
    while (pending_items.size() < 1350) begin
      quiet = ((pending_items.size() / 250) % 4 == 3);
      if ($urandom_range(0, 9) == 0) begin
        add_item(16'($urandom), 16'($urandom), 1'($urandom), quiet, 1'b0);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          // pause once mid-run until every result is out
          drain_now = (k == 0 && !drain_set && pending_items.size() > 700);
          add_item(rand_bf16(), rand_bf16(), (k == len - 1), quiet, drain_now);
          if (drain_now) drain_set = 1'b1;
        end
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_items.size() == 0 && !in_if.valid && dot_results_due.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Accumulated %0d operand pairs into %0d BF16 dot products, specials included.",
             n_items_in, n_results);
    if (n_errors == 0) begin
      $display("bf16_dot_product_fp32_accumulate: match");
    end else begin
      $display("bf16_dot_product_fp32_accumulate: mismatch");
    end
    $finish;
  end

endmodule
